// File: rtl/sha1sh_pkg.sv
// Shared types, constants and helpers for the SHA-1 stream hasher.
`default_nettype none
package sha1sh_pkg;

   localparam int WORD_W       = 32;
   localparam int DIGEST_WORDS = 5;
   localparam int BLOCK_WORDS  = 16;
   localparam int BLOCK_W      = WORD_W * BLOCK_WORDS;
   localparam int ROUNDS       = 80;
   localparam int RND_W        = $clog2(ROUNDS);
   localparam int IDX_W        = 3;

   localparam logic [7:0]  PAD_BYTE   = 8'h80;
   localparam logic [5:0]  FILL_LAST  = 6'd63;
   localparam logic [5:0]  FILL_LEN   = 6'd56;
   localparam logic [63:0] BYTE_BITS  = 64'd8;

   localparam logic [WORD_W-1:0] K_R0 = 32'h5a827999;
   localparam logic [WORD_W-1:0] K_R1 = 32'h6ed9eba1;
   localparam logic [WORD_W-1:0] K_R2 = 32'h8f1bbcdc;
   localparam logic [WORD_W-1:0] K_R3 = 32'hca62c1d6;

   // Working variables and chaining state; entry 0 is a / H0
   typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] hash_type;

   localparam hash_type H_INIT = '{
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] digest_word;
      logic [IDX_W-1:0]  word_index;
      logic              last_word;
   } rsp_type;

   typedef struct packed {
      logic start;
   } core_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_sts_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned n);
      rotl = (v << n) | (v >> (WORD_W - n));
   endfunction

endpackage
`default_nettype wire

// File: rtl/sha1sh_core.sv
// Iterative SHA-1 compression core: one round per cycle over a 16-word schedule window.
`default_nettype none
module sha1sh_core (
   input  wire                          clock,
   input  wire                          reset,
   input  sha1sh_pkg::core_cmd_type     cmd,
   input  wire [sha1sh_pkg::BLOCK_W-1:0] block,
   input  sha1sh_pkg::hash_type         h_start,
   output sha1sh_pkg::core_sts_type     sts,
   output sha1sh_pkg::hash_type         result
);
   import sha1sh_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RND_W-1:0]      rnd_ff, rnd_in;
   hash_type              var_ff, var_in;
   logic [WORD_W-1:0]     w_ff [BLOCK_WORDS];
   logic [WORD_W-1:0]     w_in [BLOCK_WORDS];
   logic [WORD_W-1:0]     f_val;
   logic [WORD_W-1:0]     k_val;
   logic [WORD_W-1:0]     w_next;
   logic [WORD_W-1:0]     tmp;
   logic                  last_rnd;

   assign last_rnd = (rnd_ff == RND_W'(ROUNDS - 1));

   always_comb begin
      if (rnd_ff < RND_W'(20)) begin
         f_val = (var_ff[1] & var_ff[2]) | (~var_ff[1] & var_ff[3]);
         k_val = K_R0;
      end else if (rnd_ff < RND_W'(40)) begin
         f_val = var_ff[1] ^ var_ff[2] ^ var_ff[3];
         k_val = K_R1;
      end else if (rnd_ff < RND_W'(60)) begin
         f_val = (var_ff[1] & var_ff[2]) | (var_ff[1] & var_ff[3]) |
                 (var_ff[2] & var_ff[3]);
         k_val = K_R2;
      end else begin
         f_val = var_ff[1] ^ var_ff[2] ^ var_ff[3];
         k_val = K_R3;
      end
      w_next = rotl(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 1);
      tmp    = rotl(var_ff[0], 5) + f_val + var_ff[4] + k_val + w_ff[0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rnd_in  = rnd_ff;
      var_in  = var_ff;
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         w_in[i] = w_ff[i];
      end
      if (cmd.start) begin
         busy_in = 1'b1;
         rnd_in  = '0;
         var_in  = h_start;
         // word 0 sits in the top bits of the block
         for (int i = 0; i < BLOCK_WORDS; i++) begin
            w_in[i] = block[BLOCK_W-1-WORD_W*i -: WORD_W];
         end
      end else if (busy_ff) begin
         var_in[0] = tmp;
         var_in[1] = var_ff[0];
         var_in[2] = rotl(var_ff[1], 30);
         var_in[3] = var_ff[2];
         var_in[4] = var_ff[3];
         // slide the schedule window, append W[t+16]
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[BLOCK_WORDS-1] = w_next;
         rnd_in = rnd_ff + RND_W'(1);
         if (last_rnd) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         rnd_ff  <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      var_ff <= var_in;
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         w_ff[i] <= w_in[i];
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = var_ff;

endmodule
`default_nettype wire

// File: rtl/sha1_stream_hasher.sv
// Top level of the SHA-1 stream hasher: byte packing, padding sequencer and digest output.
`default_nettype none
// SHA-1 over a byte stream. Each request transaction carries at most one message
// byte and an end-of-message flag; a transaction with the flag set produces five
// response transactions holding H0..H4, after which the hasher is back at its
// initial state. Bytes are accepted while idle; the 64th byte of a block starts
// the compression core, which runs one round per cycle, with req_ready low while
// it compresses. At end of message the padding bytes and the length are shifted
// in one per cycle, followed by one or two compressions and the five result words.
// The single round unit and the byte-wide block shifter set this pace.
module sha1_stream_hasher (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  sha1sh_pkg::req_type  req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output sha1sh_pkg::rsp_type  rsp_payload
);
   import sha1sh_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PAD  = 4'b0010,
      S_COMP = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [BLOCK_W-1:0]  blk_ff, blk_in;
   logic [5:0]          fill_ff, fill_in;
   logic [63:0]         bitlen_ff, bitlen_in;
   hash_type            h_ff, h_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                pad_first_ff, pad_first_in;
   logic                len_here_ff, len_here_in;
   logic                pad_mode_ff, pad_mode_in;
   logic                fin_pending_ff, fin_pending_in;
   logic                comp_last_ff, comp_last_in;

   core_cmd_type        core_cmd;
   core_sts_type        core_sts;
   hash_type            core_res;
   logic [7:0]          len_byte;
   logic [7:0]          pad_byte;
   logic                len_here_eff;
   logic                last_idx;

   sha1sh_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cmd     (core_cmd),
      .block   (blk_in),
      .h_start (h_ff),
      .sts     (core_sts),
      .result  (core_res)
   );

   // length bytes go out most significant first at fill 56..63
   assign len_byte     = 8'(bitlen_ff >> {~fill_ff[2:0], 3'b000});
   assign pad_byte     = pad_first_ff ? PAD_BYTE :
                         ((len_here_ff && fill_ff >= FILL_LEN) ? len_byte : 8'h00);
   assign len_here_eff = pad_first_ff ? (fill_ff < FILL_LEN) : len_here_ff;
   assign last_idx     = (idx_ff == IDX_W'(DIGEST_WORDS - 1));

   always_comb begin
      state_in       = state_ff;
      blk_in         = blk_ff;
      fill_in        = fill_ff;
      bitlen_in      = bitlen_ff;
      h_in           = h_ff;
      idx_in         = idx_ff;
      pad_first_in   = pad_first_ff;
      len_here_in    = len_here_ff;
      pad_mode_in    = pad_mode_ff;
      fin_pending_in = fin_pending_ff;
      comp_last_in   = comp_last_ff;
      core_cmd.start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_payload.has_byte) begin
                  blk_in    = {blk_ff[BLOCK_W-9:0], req_payload.data_byte};
                  fill_in   = fill_ff + 6'd1;
                  bitlen_in = bitlen_ff + BYTE_BITS;
               end
               if (req_payload.has_byte && fill_ff == FILL_LAST) begin
                  core_cmd.start = 1'b1;
                  state_in       = S_COMP;
                  pad_mode_in    = 1'b0;
                  fin_pending_in = req_payload.end_of_message;
               end else if (req_payload.end_of_message) begin
                  state_in     = S_PAD;
                  pad_first_in = 1'b1;
               end
            end
         end
         S_PAD: begin
            blk_in       = {blk_ff[BLOCK_W-9:0], pad_byte};
            fill_in      = fill_ff + 6'd1;
            pad_first_in = 1'b0;
            len_here_in  = len_here_eff;
            if (fill_ff == FILL_LAST) begin
               core_cmd.start = 1'b1;
               state_in       = S_COMP;
               pad_mode_in    = 1'b1;
               comp_last_in   = len_here_eff;
            end
         end
         S_COMP: begin
            if (core_sts.done) begin
               for (int i = 0; i < DIGEST_WORDS; i++) begin
                  h_in[i] = h_ff[i] + core_res[i];
               end
               if (pad_mode_ff) begin
                  if (comp_last_ff) begin
                     state_in = S_OUT;
                     idx_in   = '0;
                  end else begin
                     // length goes into a fresh all-padding block
                     state_in    = S_PAD;
                     len_here_in = 1'b1;
                  end
               end else if (fin_pending_ff) begin
                  state_in       = S_PAD;
                  pad_first_in   = 1'b1;
                  fin_pending_in = 1'b0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + IDX_W'(1);
               if (last_idx) begin
                  h_in      = H_INIT;
                  bitlen_in = '0;
                  fill_in   = '0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         fill_ff        <= '0;
         bitlen_ff      <= '0;
         h_ff           <= H_INIT;
         idx_ff         <= '0;
         pad_first_ff   <= 1'b0;
         len_here_ff    <= 1'b0;
         pad_mode_ff    <= 1'b0;
         fin_pending_ff <= 1'b0;
         comp_last_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         bitlen_ff      <= bitlen_in;
         h_ff           <= h_in;
         idx_ff         <= idx_in;
         pad_first_ff   <= pad_first_in;
         len_here_ff    <= len_here_in;
         pad_mode_ff    <= pad_mode_in;
         fin_pending_ff <= fin_pending_in;
         comp_last_ff   <= comp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

   assign req_ready               = (state_ff == S_IDLE);
   assign rsp_valid               = (state_ff == S_OUT);
   assign rsp_payload.digest_word = h_ff[idx_ff];
   assign rsp_payload.word_index  = idx_ff;
   assign rsp_payload.last_word   = last_idx;

   a_done_in_comp: assert property (@(posedge clock) disable iff (reset)
      core_sts.done |-> state_ff == S_COMP)
      else $error("compression finished outside the compress state");

   a_core_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMP && !core_sts.done) |-> core_sts.busy)
      else $error("waiting on an idle compression core");

   a_out_from_comp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_COMP)
      else $error("digest shown without a final compression");

   a_clean_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_payload.last_word) |=>
         (req_ready && fill_ff == '0 && bitlen_ff == '0 && h_ff == H_INIT))
      else $error("state not restored after the last digest word");

endmodule
`default_nettype wire

// File: tb/sha1_stream_hasher_test.sv
// Self-checking testbench for the SHA-1 stream hasher with an in-bench digest predictor.
`default_nettype none
module sha1_stream_hasher_test;
   import sha1sh_pkg::*;

   // Tracks the hash of the message in flight and holds the digest words still due.
   class sha1_digest_tracker;
      typedef logic [31:0] block_words_t [16];

      logic [31:0]  chain [5];
      block_words_t held;
      int unsigned  fill;
      logic [63:0]  bit_count;
      rsp_type      digest_queue [$];
      int unsigned  errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0};
         held = '{default: '0};
         fill = 0;
         bit_count = '0;
      endfunction

      function logic [31:0] rol32(logic [31:0] v, int unsigned n);
         return (v << n) | (v >> (32 - n));
      endfunction

      function void compress_block(block_words_t blk);
         logic [31:0] w [16];
         logic [31:0] a, b, c, d, e, f, k, wt, t_sum;
         int unsigned t;
         w = blk;
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
         for (t = 0; t < 80; t++) begin
            if (t < 16) begin
               wt = w[t];
            end else begin
               wt = rol32(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
               w[t % 16] = wt;
            end
            if (t < 20) begin
               f = (b & c) | (~b & d);
               k = 32'h5a827999;
            end else if (t < 40) begin
               f = b ^ c ^ d;
               k = 32'h6ed9eba1;
            end else if (t < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = 32'h8f1bbcdc;
            end else begin
               f = b ^ c ^ d;
               k = 32'hca62c1d6;
            end
            t_sum = rol32(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t_sum;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
      endfunction

      function void absorb_request(req_type r);
         block_words_t pad;
         rsp_type      word;
         int unsigned  wi, sh, i;
         if (r.has_byte) begin
            wi = fill / 4;
            sh = 24 - 8 * (fill % 4);
            if (fill % 4 == 0)
               held[wi] = {r.data_byte, 24'h0};
            else
               held[wi] |= {24'h0, r.data_byte} << sh;
            bit_count += 64'd8;
            fill++;
            if (fill == 64) begin
               compress_block(held);
               fill = 0;
            end
         end
         if (!r.end_of_message)
            return;
         // pad: 0x80 after the last byte, zeros, then the bit length
         wi = fill / 4;
         sh = 24 - 8 * (fill % 4);
         for (i = 0; i < 16; i++)
            pad[i] = (i < wi) ? held[i] : '0;
         if (fill % 4 != 0)
            pad[wi] = held[wi];
         pad[wi] |= 32'h80 << sh;
         if (fill >= 56) begin
            compress_block(pad);
            pad = '{default: '0};
         end
         pad[14] = bit_count[63:32];
         pad[15] = bit_count[31:0];
         compress_block(pad);
         for (i = 0; i < 5; i++) begin
            word.digest_word = chain[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == 4);
            digest_queue.push_back(word);
         end
         restart();
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (digest_queue.size() == 0) begin
            $error("unexpected digest word %h, index %0d", got.digest_word, got.word_index);
            errors++;
            return;
         end
         want = digest_queue.pop_front();
         if (got.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, actual %h", want.digest_word, got.digest_word);
            errors++;
         end
         if (got.word_index !== want.word_index) begin
            $error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
            errors++;
         end
         if (got.last_word !== want.last_word) begin
            $error("last_word: expected %0b, actual %0b", want.last_word, got.last_word);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return digest_queue.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   sha1_digest_tracker tracker = new();
   bit          quiet = 1'b0;
   int unsigned items_sent = 0;
   int unsigned messages_sent = 0;

   sha1_stream_hasher dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.absorb_request(req_payload);
         if (rsp_valid && rsp_ready)
            tracker.check_response(rsp_payload);
      end
   end

   // Stall the digest output in bursts, except in the closing stretch.
   initial begin
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   function automatic req_type mk(logic [7:0] data, logic has, logic fin);
      req_type it;
      it.data_byte      = data;
      it.has_byte       = has;
      it.end_of_message = fin;
      return it;
   endfunction

   // Hold valid and payload until the transaction is taken.
   task automatic send_item(input req_type it, input bit may_idle);
      if (may_idle && !quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (it.has_byte || it.end_of_message)
         items_sent++;
   endtask

   task automatic send_message(input int len, input bit end_alone, input bit may_idle);
      int i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_item(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0), may_idle);
         send_item(mk(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !end_alone),
                   may_idle);
      end
      if (len == 0 || end_alone)
         send_item(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1), may_idle);
      messages_sent++;
   endtask

   initial begin
      int boundary_lens [10];
      int len;
      int unsigned target, waited;

      boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty messages, short messages, byte and end together
      send_item(mk(8'hff, 1'b0, 1'b0), 1'b0);
      send_item(mk(8'h00, 1'b0, 1'b1), 1'b0);
      send_item(mk(8'h61, 1'b1, 1'b0), 1'b0);
      send_item(mk(8'h62, 1'b1, 1'b0), 1'b0);
      send_item(mk(8'h63, 1'b1, 1'b1), 1'b0);
      send_item(mk(8'hff, 1'b1, 1'b1), 1'b0);
      send_item(mk(8'h00, 1'b1, 1'b0), 1'b0);
      send_item(mk(8'h5a, 1'b0, 1'b1), 1'b0);
      send_item(mk(8'ha5, 1'b0, 1'b0), 1'b0);
      send_item(mk(8'h3c, 1'b0, 1'b1), 1'b0);
      send_item(mk(8'h80, 1'b1, 1'b0), 1'b1);
      send_item(mk(8'h7f, 1'b1, 1'b0), 1'b1);
      send_item(mk(8'h01, 1'b1, 1'b0), 1'b1);
      send_item(mk(8'hfe, 1'b1, 1'b1), 1'b1);
      send_message(5, 1'b1, 1'b1);

      // random messages, mostly short, some around the padding boundaries
      while (items_sent < 350 || messages_sent < 16) begin
         if ($urandom_range(0, 7) == 0)
            len = boundary_lens[$urandom_range(0, 9)];
         else
            len = $urandom_range(0, 12);
         send_message(len, $urandom_range(0, 1), $urandom_range(0, 3) != 0);
      end

      // closing stretch at full rate on both sides
      quiet = 1'b1;
      target = items_sent + 50;
      send_message(64, 1'b0, 1'b0);
      while (items_sent < target)
         send_message($urandom_range(0, 12), $urandom_range(0, 1), 1'b0);
      req_valid <= 1'b0;

      waited = 0;
      while (tracker.pending() != 0 && waited < 200_000) begin
         @(posedge clock);
         waited++;
      end
      if (tracker.pending() != 0) begin
         $display("FAIL");
         $finish;
      end else begin
         repeat (300) @(posedge clock);
         if (tracker.errors == 0)
            $display("PASS");
         else
            $display("FAIL");
         $finish;
      end
   end

endmodule
`default_nettype wire
